// File: src/aes128_pkg.sv
package aes128_pkg;

  typedef logic [127:0] block_t;
  typedef logic [10:0][127:0] round_keys_t;

  typedef struct packed {
    logic busy;
  } key_status_t;

  localparam int unsigned NumRounds = 10;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
    8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
    8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
    8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
    8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
    8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
    8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
    8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
    8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
    8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
    8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
    8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
    8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
    8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
    8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
  };

  localparam logic [7:0] RCON [11] = '{
    8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1B,8'h36
  };

  // register indexes of the configuration port
  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  // operation codes
  localparam logic KIND_ENC = 1'b0;
  localparam logic KIND_DEC = 1'b1;

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
  endfunction

endpackage

// File: src/aes128_key_exp.sv
module aes128_key_exp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [63:0]                 cfg_data,
  output aes128_pkg::round_keys_t     round_keys,
  output aes128_pkg::key_status_t     status
);

  logic [63:0]             key_high;
  logic [63:0]             key_low;
  logic                    busy;
  logic [3:0]              cnt;
  aes128_pkg::block_t      cur;
  aes128_pkg::block_t      cur_next;
  aes128_pkg::round_keys_t keys;
  logic [31:0]             temp;
  logic [31:0]             w4, w5, w6, w7;

  // one round key from the previous one, or the key itself when cnt is zero
  always_comb begin
    temp = {aes128_pkg::SBOX[cur[23:16]] ^ aes128_pkg::RCON[cnt],
            aes128_pkg::SBOX[cur[15:8]],
            aes128_pkg::SBOX[cur[7:0]],
            aes128_pkg::SBOX[cur[31:24]]};
    w4 = cur[127:96] ^ temp;
    w5 = cur[95:64] ^ w4;
    w6 = cur[63:32] ^ w5;
    w7 = cur[31:0] ^ w6;
    if (cnt == 4'd0) begin
      cur_next = {key_high, key_low};
    end else begin
      cur_next = {w4, w5, w6, w7};
    end
  end

  // key registers and expansion sequencer, one round key a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      busy     <= 1'b1;
      cnt      <= '0;
    end else if (cfg_we) begin
      if (cfg_index == aes128_pkg::REG_KEY_HIGH) begin
        key_high <= cfg_data;
      end else begin
        key_low <= cfg_data;
      end
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      if (cnt == 4'(aes128_pkg::NumRounds)) begin
        busy <= 1'b0;
      end
      cnt <= cnt + 4'd1;
    end
  end

  // round key store
  always_ff @(posedge clk) begin
    if (busy && !cfg_we) begin
      cur       <= cur_next;
      keys[cnt] <= cur_next;
    end
  end

  assign round_keys  = keys;
  assign status.busy = busy;

endmodule

// File: src/aes128_round.sv
module aes128_round (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               final_rnd,
  input  logic               in_v,
  input  aes128_pkg::block_t in_state,
  input  logic               in_kind,
  input  logic               in_last,
  input  aes128_pkg::block_t key_enc,
  input  aes128_pkg::block_t key_dec,
  output logic               out_v,
  output aes128_pkg::block_t out_state,
  output logic               out_kind,
  output logic               out_last
);

  logic [7:0]         s [16];
  logic [7:0]         t [16];
  logic [7:0]         a [16];
  logic [7:0]         m [16];
  logic [7:0]         o [16];
  logic               dec;
  aes128_pkg::block_t res;

  // one round, forward or inverse
  always_comb begin
    logic [7:0] v0, v1, v2, v3;
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] kb;
    dec = (in_kind == aes128_pkg::KIND_DEC);
    for (int i = 0; i < 16; i++) begin
      s[i] = in_state[127 - 8*i -: 8];
    end
    // byte substitution and row shift
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (dec) begin
          t[r + 4*c] = aes128_pkg::INV_SBOX[s[r + 4*((c - r + 4) % 4)]];
        end else begin
          t[r + 4*c] = aes128_pkg::SBOX[s[r + 4*((c + r) % 4)]];
        end
      end
    end
    // inverse path adds the key before mixing
    for (int i = 0; i < 16; i++) begin
      kb   = key_dec[127 - 8*i -: 8];
      a[i] = dec ? (t[i] ^ kb) : t[i];
    end
    // column mixing
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        x2[r] = aes128_pkg::xtime(a[r + 4*c]);
        x4[r] = aes128_pkg::xtime(x2[r]);
        x8[r] = aes128_pkg::xtime(x4[r]);
      end
      for (int r = 0; r < 4; r++) begin
        if (dec) begin
          v0 = x8[r] ^ x4[r] ^ x2[r];
          v1 = x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4 + 4*c];
          v2 = x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4 + 4*c];
          v3 = x8[(r+3)%4] ^ a[(r+3)%4 + 4*c];
        end else begin
          v0 = x2[r];
          v1 = x2[(r+1)%4] ^ a[(r+1)%4 + 4*c];
          v2 = a[(r+2)%4 + 4*c];
          v3 = a[(r+3)%4 + 4*c];
        end
        m[r + 4*c] = final_rnd ? a[r + 4*c] : (v0 ^ v1 ^ v2 ^ v3);
      end
    end
    // forward path adds the key last
    for (int i = 0; i < 16; i++) begin
      kb   = key_enc[127 - 8*i -: 8];
      o[i] = dec ? m[i] : (m[i] ^ kb);
      res[127 - 8*i -: 8] = o[i];
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_state <= res;
      out_kind  <= in_kind;
      out_last  <= in_last;
    end
  end

endmodule

// File: src/aes128_block_cipher_top.sv
// aes-128 ecb cipher, one 128-bit block per item
// input channel: in_valid/in_stall with kind (0 encrypt, 1 decrypt),
//   block_high, block_low and last_block; byte 0 sits in block_high[63:56]
// output channel: out_valid/out_stall with result_high, result_low and
//   result_last, which is last_block carried through unchanged
// key: write key_high (index 0) and key_low (index 1) on cfg_we; each write
//   starts an expansion of the 11 round keys, during which in_stall is
//   held high
// reset: keys clear to zero and the zero key is expanded, so in_stall stays
//   high until that expansion ends
// pipeline: eleven registers, one key-add stage and ten round stages
// throughput: one item per cycle unless out_stall or a key expansion holds
//   it; each round stage holds its item only while the next one is full and
//   stalled, so a stall on out_stall fills bubbles first and reaches
//   in_stall once all eleven stages are occupied
module aes128_block_cipher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  input  logic        last_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_high,
  output logic [63:0] result_low,
  output logic        result_last
);

  aes128_pkg::round_keys_t rk;
  aes128_pkg::key_status_t kstat;

  logic               v    [11];
  aes128_pkg::block_t st   [11];
  logic               knd  [11];
  logic               lst  [11];
  logic               adv  [11];
  aes128_pkg::block_t ark0;

  aes128_key_exp u_key_exp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .round_keys (rk),
    .status     (kstat)
  );

  // stage advance chain, back from the output register
  always_comb begin
    adv[10] = !v[10] || !out_stall;
    for (int k = 9; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign in_stall = kstat.busy || !adv[0];

  // initial key add
  assign ark0 = {block_high, block_low} ^
                ((kind == aes128_pkg::KIND_DEC) ? rk[10] : rk[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv[0]) begin
      v[0] <= in_valid && !kstat.busy;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      st[0]  <= ark0;
      knd[0] <= kind;
      lst[0] <= last_block;
    end
  end

  // ten round stages
  for (genvar j = 1; j <= 10; j++) begin : g_round
    aes128_round u_round (
      .clk       (clk),
      .rst       (rst),
      .en        (adv[j]),
      .final_rnd (j == 10),
      .in_v      (v[j-1]),
      .in_state  (st[j-1]),
      .in_kind   (knd[j-1]),
      .in_last   (lst[j-1]),
      .key_enc   (rk[j]),
      .key_dec   (rk[10-j]),
      .out_v     (v[j]),
      .out_state (st[j]),
      .out_kind  (knd[j]),
      .out_last  (lst[j])
    );
  end

  assign out_valid   = v[10];
  assign result_high = st[10][127:64];
  assign result_low  = st[10][63:0];
  assign result_last = lst[10];

`ifndef SYNTHESIS
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    kstat.busy |-> in_stall)
    else $error("item accepted during key expansion");

  a_write_starts_expansion: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> kstat.busy)
    else $error("key write did not start expansion");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v[0])
    else $error("accepted item lost at first stage");

  a_output_holds: assert property (@(posedge clk) disable iff (rst)
    (v[10] && out_stall) |=> (v[10] && $stable(st[10])))
    else $error("stalled result changed");
`endif

endmodule

// File: test/aes128_block_cipher_checker.sv
module aes128_block_cipher_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        kind,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  input  logic        last_block,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] result_high,
  input  logic [63:0] result_low,
  input  logic        result_last,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [63:0] high;
    logic [63:0] low;
    logic        last;
  } cipher_out_t;

  logic [63:0] key_hi_copy;
  logic [63:0] key_lo_copy;
  logic [7:0]  sched [176];
  cipher_out_t expected_blocks [$];

  // field multiply by two
  function automatic logic [7:0] gf_double(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
  endfunction

  // field multiply by a small constant
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] bb;
    acc = 8'h00;
    bb = b;
    for (int i = 0; i < 4; i++) begin
      if (a[i]) acc ^= bb;
      bb = gf_double(bb);
    end
    return acc;
  endfunction

  // key schedule from the held key
  task automatic expand_schedule();
    logic [7:0] t [4];
    logic [7:0] first;
    for (int i = 0; i < 8; i++) begin
      sched[i]     = key_hi_copy[63-8*i -: 8];
      sched[8 + i] = key_lo_copy[63-8*i -: 8];
    end
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) t[j] = sched[4*(i-1) + j];
      if ((i % 4) == 0) begin
        first = t[0];
        t[0] = aes128_pkg::SBOX[t[1]] ^ aes128_pkg::RCON[i/4];
        t[1] = aes128_pkg::SBOX[t[2]];
        t[2] = aes128_pkg::SBOX[t[3]];
        t[3] = aes128_pkg::SBOX[first];
      end
      for (int j = 0; j < 4; j++) sched[4*i + j] = sched[4*(i-4) + j] ^ t[j];
    end
  endtask

  // one full block through the cipher or its inverse
  function automatic logic [127:0] run_cipher(input logic [127:0] blk, input logic dec);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] v [4];
    logic [7:0] m0, m1, m2, m3;
    logic [127:0] res;
    int rnd, src;
    m0 = dec ? 8'h0E : 8'h02;
    m1 = dec ? 8'h0B : 8'h03;
    m2 = dec ? 8'h0D : 8'h01;
    m3 = dec ? 8'h09 : 8'h01;
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
    rnd = dec ? 10 : 0;
    for (int i = 0; i < 16; i++) s[i] ^= sched[16*rnd + i];
    for (int step = 1; step <= 10; step++) begin
      rnd = dec ? 10 - step : step;
      // shift rows then byte substitution (order is irrelevant)
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) begin
          src = dec ? ((c - r + 4) % 4) : ((c + r) % 4);
          t[r + 4*c] = s[r + 4*src];
        end
      for (int i = 0; i < 16; i++)
        s[i] = dec ? aes128_pkg::INV_SBOX[t[i]] : aes128_pkg::SBOX[t[i]];
      if (dec) for (int i = 0; i < 16; i++) s[i] ^= sched[16*rnd + i];
      if (step != 10) begin
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) v[r] = s[r + 4*c];
          for (int r = 0; r < 4; r++)
            s[r + 4*c] = gf_mul(m0, v[r]) ^ gf_mul(m1, v[(r+1)%4])
                       ^ gf_mul(m2, v[(r+2)%4]) ^ gf_mul(m3, v[(r+3)%4]);
        end
      end
      if (!dec) for (int i = 0; i < 16; i++) s[i] ^= sched[16*rnd + i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
    return res;
  endfunction

  // key tracking, prediction and comparison
  always @(posedge clk) begin
    cipher_out_t want;
    logic [127:0] ct;
    bit bad;
    if (rst) begin
      key_hi_copy = '0;
      key_lo_copy = '0;
      expand_schedule();
      expected_blocks.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == aes128_pkg::REG_KEY_HIGH) key_hi_copy = cfg_data;
        else key_lo_copy = cfg_data;
        expand_schedule();
      end
      if (out_valid && !out_stall) begin
        if (expected_blocks.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result item %h %h %b", result_high, result_low, result_last);
        end else begin
          want = expected_blocks.pop_front();
          bad = (want.high !== result_high) || (want.low !== result_low)
             || (want.last !== result_last);
          if (bad) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %h %h %b, got %h %h %b",
                       want.high, want.low, want.last,
                       result_high, result_low, result_last);
          end
        end
      end
      if (in_valid && !in_stall) begin
        ct = run_cipher({block_high, block_low}, kind == aes128_pkg::KIND_DEC);
        want.high = ct[127:64];
        want.low  = ct[63:0];
        want.last = last_block;
        expected_blocks.push_back(want);
      end
    end
    pending = expected_blocks.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end

endmodule

// File: test/tb_aes128_block_cipher_top.sv
module tb_aes128_block_cipher_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        kind;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic        last_block;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] result_high;
  logic [63:0] result_low;
  logic        result_last;
  int          fail_count;
  int          pending;
  bit          hold_request;
  bit          steady_phase;

  aes128_block_cipher_top u_top (.*);

  aes128_block_cipher_checker u_checker (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // overall time limit
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_phase || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // receiver: random stalls, one long hold when asked
  initial begin
    bit held;
    int run;
    out_stall = 1'b0;
    held = 0;
    run = 0;
    forever begin
      @(posedge clk);
      if (hold_request && !held) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (120) @(posedge clk);
        out_stall <= 1'b0;
      end else if (run > 0) begin
        run--;
      end else if (steady_phase) begin
        out_stall <= 1'b0;
      end else begin
        run = pick_gap();
        out_stall <= (run > 0);
      end
    end
  end

  // offer one item and hold it until accepted
  task automatic send_block(input logic k, input logic [63:0] hi, input logic [63:0] lo,
                            input logic lst);
    int gap;
    in_valid   <= 1'b1;
    kind       <= k;
    block_high <= hi;
    block_low  <= lo;
    last_block <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and wait for every result to come back
  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (15) @(posedge clk);
  endtask

  task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
    cfg_we    <= 1'b1;
    cfg_index <= aes128_pkg::REG_KEY_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_index <= aes128_pkg::REG_KEY_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_blocks(input int count);
    logic [63:0] hi, lo;
    logic k;
    int sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 9);
      hi = rand64();
      lo = rand64();
      // occasional all-ones or all-zero halves
      if (sel == 0) hi = '1;
      if (sel == 1) lo = '0;
      k = 1'($urandom_range(0, 1));
      send_block(k, hi, lo, ($urandom_range(0, 3) == 0));
    end
  endtask

  // stimulus and verdict
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = aes128_pkg::REG_KEY_HIGH;
    cfg_data = '0;
    in_valid = 1'b0;
    kind = aes128_pkg::KIND_ENC;
    block_high = '0;
    block_low = '0;
    last_block = 1'b0;
    hold_request = 0;
    steady_phase = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero key straight from reset, extreme blocks
    send_block(aes128_pkg::KIND_ENC, '0, '0, 1'b0);
    send_block(aes128_pkg::KIND_DEC, '0, '0, 1'b1);
    send_block(aes128_pkg::KIND_ENC, '1, '1, 1'b1);
    send_block(aes128_pkg::KIND_DEC, '1, '1, 1'b0);
    send_block(aes128_pkg::KIND_ENC, 64'h0011223344556677, 64'h8899AABBCCDDEEFF, 1'b0);
    drain();

    // standard test key with its known vector both ways
    write_key(64'h0001020304050607, 64'h08090A0B0C0D0E0F);
    send_block(aes128_pkg::KIND_ENC, 64'h0011223344556677, 64'h8899AABBCCDDEEFF, 1'b1);
    send_block(aes128_pkg::KIND_DEC, 64'h69C4E0D86A7B0430, 64'hD8CDB78070B4C55A, 1'b0);
    send_block(aes128_pkg::KIND_ENC, '0, '1, 1'b0);
    send_block(aes128_pkg::KIND_DEC, '1, '0, 1'b1);
    drain();

    // all-ones key, back to back with no idling
    write_key('1, '1);
    steady_phase = 1;
    send_block(aes128_pkg::KIND_ENC, '0, '0, 1'b0);
    send_block(aes128_pkg::KIND_DEC, '0, '0, 1'b1);
    random_blocks(150);
    steady_phase = 0;
    drain();

    // random keys, one phase with the long receiver hold
    for (int ph = 0; ph < 5; ph++) begin
      write_key(rand64(), rand64());
      if (ph == 1) hold_request = 1;
      random_blocks(290);
      drain();
    end

    // back to the zero key
    write_key('0, '0);
    random_blocks(20);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
